FILE: hdl/sccalloc_pkg.sv
// ---------------------------------------------------------------------------
// sccalloc_pkg
// Shared types and constants for the size-class chunk allocator.
// ---------------------------------------------------------------------------
package sccalloc_pkg;

  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned ADDR_W    = 18;
  localparam int unsigned LIMIT_W   = 7;
  localparam int unsigned CLS_OUT_W = 3;
  localparam int unsigned TAG_W     = 4;
  localparam int unsigned LEFT_W    = 9;
  localparam int unsigned PAGE_GRAN = 256;
  localparam logic [TAG_W-1:0] TAG_INVALID = 4'hF;
  localparam logic [3:0]       HEADER_LOW  = 4'b1000;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ALLOCATED    = 3'd0,
    ST_FREED        = 3'd1,
    ST_ZERO_SIZE    = 3'd2,
    ST_TOO_LARGE    = 3'd3,
    ST_OUT_OF_PAGES = 3'd4,
    ST_FREE_IGNORED = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_EXEC
  } fsm_e;

  typedef struct packed {
    logic capture;
    logic execute;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
  } dp_stat_t;

endpackage

FILE: hdl/sccalloc_ctrl.sv
// ---------------------------------------------------------------------------
// sccalloc_ctrl
// Sequencer: tag clearing pass, request capture, execute, result handoff.
// ---------------------------------------------------------------------------
module sccalloc_ctrl
  import sccalloc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dp_cmd_t  dp_cmd_o,
  input  dp_stat_t dp_stat_i
);

  fsm_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    dp_cmd_o         = '0;
    in_ready_o       = 1'b0;
    out_valid_d      = out_valid_q && !out_ready_i;
    case (state_q)
      FSM_CLEAR: begin
        dp_cmd_o.clear = 1'b1;
        if (dp_stat_i.clear_done) state_d = FSM_IDLE;
      end
      FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          dp_cmd_o.capture = 1'b1;
          state_d          = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        // hold until the result slot is free or draining
        if (!out_valid_q || out_ready_i) begin
          dp_cmd_o.execute = 1'b1;
          out_valid_d      = 1'b1;
          state_d          = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/sccalloc_dp.sv
// ---------------------------------------------------------------------------
// sccalloc_dp
// Free-list heads, carve cursors, link and tag memories, result register.
// ---------------------------------------------------------------------------
module sccalloc_dp
  import sccalloc_pkg::*;
#(
  parameter int unsigned CLASS_COUNT = 8,
  parameter int unsigned MAX_PAGES   = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              dp_cmd_i,
  output dp_stat_t             dp_stat_o,
  input  logic                 cfg_valid_i,
  input  logic [LIMIT_W-1:0]   cfg_data_i,
  input  logic                 command_i,
  input  logic [SIZE_W-1:0]    request_size_i,
  input  logic [ADDR_W-1:0]    user_address_i,
  output logic [2:0]           status_o,
  output logic [ADDR_W-1:0]    granted_address_o,
  output logic [CLS_OUT_W-1:0] size_class_o
);

  localparam int unsigned GRAN_COUNT = MAX_PAGES * PAGE_GRAN;
  localparam int unsigned GW  = $clog2(GRAN_COUNT);
  localparam int unsigned PW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned PTW = $clog2(MAX_PAGES + 1);
  localparam int unsigned CI  = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int unsigned FW  = ADDR_W - 4;

  // per-class state
  logic [GW-1:0]     head_q       [CLASS_COUNT];
  logic [GW-1:0]     head_d       [CLASS_COUNT];
  logic              head_empty_q [CLASS_COUNT];
  logic              head_empty_d [CLASS_COUNT];
  logic [PW-1:0]     cpage_q      [CLASS_COUNT];
  logic [PW-1:0]     cpage_d      [CLASS_COUNT];
  logic [LEFT_W-1:0] cleft_q      [CLASS_COUNT];
  logic [LEFT_W-1:0] cleft_d      [CLASS_COUNT];
  logic [PTW-1:0]    pages_q, pages_d;
  logic [LIMIT_W-1:0] limit_q;

  // memories
  logic [GW:0]      link_mem [GRAN_COUNT];
  logic [TAG_W-1:0] tag_mem  [GRAN_COUNT];
  logic [GW:0]      link_rd_q;
  logic [TAG_W-1:0] tag_rd_q;

  // captured request
  logic             cmd_q;
  logic [TAG_W-1:0] cls_q;
  logic             zero_q, big_q, bad_q;
  logic [GW-1:0]    gfree_q;
  logic [GW-1:0]    clr_q;

  // result register
  status_e          st_q, st_d;
  logic [ADDR_W-1:0] ga_q, ga_d;
  logic [TAG_W-1:0] rc_q, rc_d;

  // capture-side decode
  logic [16:0]      total;
  logic [TAG_W-1:0] cls_in;
  logic             fit_in;
  logic [ADDR_W-1:0] h_in;
  logic [FW-1:0]    gfull_in;
  logic             bad_in;
  logic [GW-1:0]    gfree_in;

  always_comb begin
    total  = 17'(request_size_i) + 17'd8;
    cls_in = '0;
    fit_in = 1'b0;
    for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
      if ((17'd16 << c) >= total) begin
        cls_in = TAG_W'(c);
        fit_in = 1'b1;
      end
    end
    h_in     = user_address_i - ADDR_W'(8);
    gfull_in = h_in[ADDR_W-1:4];
    bad_in   = (user_address_i < ADDR_W'(8)) || (h_in[3:0] != 4'd0) ||
               (17'(gfull_in) >= 17'(GRAN_COUNT));
    gfree_in = bad_in ? '0 : GW'(gfull_in);
  end

  // execute-side logic
  logic [CI-1:0]     ci, ti;
  logic              tag_we, link_we;
  logic [GW-1:0]     tag_wa, g;
  logic [TAG_W-1:0]  tag_wd;
  logic [GW:0]       link_wd;
  logic [LEFT_W-1:0] left_m1, fresh_m1;
  logic [8:0]        lim;

  always_comb begin
    ci       = cls_q[CI-1:0];
    ti       = tag_rd_q[CI-1:0];
    head_d       = head_q;
    head_empty_d = head_empty_q;
    cpage_d  = cpage_q;
    cleft_d  = cleft_q;
    pages_d  = pages_q;
    st_d     = st_q;
    ga_d     = ga_q;
    rc_d     = rc_q;
    tag_we   = 1'b0;
    tag_wa   = clr_q;
    tag_wd   = TAG_INVALID;
    link_we  = 1'b0;
    link_wd  = {head_empty_q[ti], head_q[ti]};
    g        = '0;
    left_m1  = cleft_q[ci] - LEFT_W'(1);
    fresh_m1 = LEFT_W'(PAGE_GRAN >> cls_q) - LEFT_W'(1);
    lim      = ({2'b0, limit_q} > 9'(MAX_PAGES)) ? 9'(MAX_PAGES) : {2'b0, limit_q};
    if (dp_cmd_i.clear) begin
      tag_we = 1'b1;
    end else if (dp_cmd_i.execute) begin
      ga_d = '0;
      rc_d = '0;
      if (cmd_q == CMD_ALLOC) begin
        if (zero_q) begin
          st_d = ST_ZERO_SIZE;
        end else if (big_q) begin
          st_d = ST_TOO_LARGE;
        end else begin
          rc_d = cls_q;
          st_d = ST_ALLOCATED;
          if (!head_empty_q[ci]) begin
            // pop
            g               = head_q[ci];
            head_d[ci]      = link_rd_q[GW-1:0];
            head_empty_d[ci] = link_rd_q[GW];
          end else if (cleft_q[ci] != '0) begin
            cleft_d[ci] = left_m1;
            g = GW'({cpage_q[ci], 8'(left_m1 << cls_q)});
          end else if (9'(pages_q) < lim) begin
            cpage_d[ci] = PW'(pages_q);
            cleft_d[ci] = fresh_m1;
            pages_d     = pages_q + PTW'(1);
            g = GW'({PW'(pages_q), 8'(fresh_m1 << cls_q)});
          end else begin
            st_d = ST_OUT_OF_PAGES;
          end
          if (st_d == ST_ALLOCATED) begin
            tag_we = 1'b1;
            tag_wa = g;
            tag_wd = cls_q;
            ga_d   = ADDR_W'({g, HEADER_LOW});
          end
        end
      end else begin
        if (bad_q || (32'(tag_rd_q) >= 32'(CLASS_COUNT))) begin
          st_d = ST_FREE_IGNORED;
        end else begin
          st_d             = ST_FREED;
          rc_d             = tag_rd_q;
          tag_we           = 1'b1;
          tag_wa           = gfree_q;
          link_we          = 1'b1;
          head_d[ti]       = gfree_q;
          head_empty_d[ti] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
        head_empty_q[c] <= 1'b1;
        cpage_q[c]      <= '0;
        cleft_q[c]      <= '0;
      end
      pages_q <= '0;
      limit_q <= LIMIT_W'(64);
      clr_q   <= '0;
    end else begin
      head_empty_q <= head_empty_d;
      cpage_q      <= cpage_d;
      cleft_q      <= cleft_d;
      pages_q      <= pages_d;
      if (cfg_valid_i) limit_q <= cfg_data_i;
      if (dp_cmd_i.clear) clr_q <= clr_q + GW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    st_q   <= st_d;
    ga_q   <= ga_d;
    rc_q   <= rc_d;
    if (dp_cmd_i.capture) begin
      cmd_q   <= command_i;
      cls_q   <= cls_in;
      zero_q  <= (request_size_i == '0);
      big_q   <= !fit_in;
      bad_q   <= bad_in;
      gfree_q <= gfree_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.capture) link_rd_q <= link_mem[head_q[cls_in[CI-1:0]]];
    if (link_we) link_mem[gfree_q] <= link_wd;
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.capture) tag_rd_q <= tag_mem[gfree_in];
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
  end

  assign dp_stat_o.clear_done = (32'(clr_q) == GRAN_COUNT - 1);
  assign status_o          = st_q;
  assign granted_address_o = ga_q;
  assign size_class_o      = rc_q[CLS_OUT_W-1:0];

endmodule

FILE: hdl/size_class_chunk_allocator.sv
// ---------------------------------------------------------------------------
// size_class_chunk_allocator
// Segregated free-list heap allocator with per-class page carving.
// ---------------------------------------------------------------------------
// Request channel (in_valid_i/in_ready_o): one beat carries an allocate or a
// free. Allocates round size+8 up to a class of 16<<i bytes, pop that class's
// LIFO list, or carve the next chunk (highest first) of the class page, or
// take a fresh page while the page limit allows.
// Result channel (out_valid_o/out_ready_i): exactly one beat per request with
// status, granted heap offset and class.
// Config channel (cfg_valid_i/cfg_ready_o): writes page_limit; always ready.
// Sequence: an item is captured (link and tag memory reads issued), then
// executed (list, cursor and memory updates, result registered). A new
// request is taken only after the last one has executed; the link and tag
// memories with registered read data are read at capture, written at execute.
// A finished result sits in the output register; the next request is still
// accepted, and its execute step waits only while that result is unclaimed.
// Reset: after reset the tag memory is swept to invalid, one entry a cycle,
// all MAX_PAGES*256 entries (16384 by default), with in_ready_o low meanwhile.
// ---------------------------------------------------------------------------
module size_class_chunk_allocator
  import sccalloc_pkg::*;
#(
  parameter int unsigned CLASS_COUNT = 8,
  parameter int unsigned MAX_PAGES   = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 command_i,
  input  logic [SIZE_W-1:0]    request_size_i,
  input  logic [ADDR_W-1:0]    user_address_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           status_o,
  output logic [ADDR_W-1:0]    granted_address_o,
  output logic [CLS_OUT_W-1:0] size_class_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [LIMIT_W-1:0]   cfg_data_i
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencer: clear sweep, capture, execute
  sccalloc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dp_cmd_o    (dp_cmd),
    .dp_stat_i   (dp_stat)
  );

  // lists, cursors, memories and the result register
  sccalloc_dp #(
    .CLASS_COUNT (CLASS_COUNT),
    .MAX_PAGES   (MAX_PAGES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .dp_cmd_i          (dp_cmd),
    .dp_stat_o         (dp_stat),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .command_i         (command_i),
    .request_size_i    (request_size_i),
    .user_address_i    (user_address_i),
    .status_o          (status_o),
    .granted_address_o (granted_address_o),
    .size_class_o      (size_class_o)
  );

  // the limit register takes a write in any cycle
  assign cfg_ready_o = 1'b1;

endmodule
